// File: rtl/core/thst_pkg.sv
// ----------------------------------------------------------------------------
// thst_pkg
// Shared types and constants for the tracked hand slot table: command codes,
// register indexes, reset values, slot record and squaring unit operations.
// ----------------------------------------------------------------------------
package thst_pkg;

    // Commands carried in the input request
    localparam logic [1:0] CMD_GESTURE = 2'd0;
    localparam logic [1:0] CMD_CREATE  = 2'd1;
    localparam logic [1:0] CMD_UPDATE  = 2'd2;
    localparam logic [1:0] CMD_DESTROY = 2'd3;

    // Register indexes (byte address bit 2)
    localparam logic REG_MIN_SPACING  = 1'b0;
    localparam logic REG_SLOTS_IN_USE = 1'b1;

    localparam int MIN_DIST_W = 14;
    localparam int USE_W      = 3;
    localparam int POS_W      = 15;
    localparam int ID_W       = 32;
    localparam int ACC_W      = 32;
    localparam int MD2_W      = 2 * MIN_DIST_W;
    localparam int SLOT_IDX_W = 2;
    localparam int COUNT_W    = 3;

    localparam logic [MIN_DIST_W-1:0] MIN_SPACING_RESET  = 14'd100;
    localparam logic [USE_W-1:0]      SLOTS_IN_USE_RESET = 3'd4;

    // Operations of the shared squaring unit
    localparam logic [1:0] SQ_HOLD = 2'd0;
    localparam logic [1:0] SQ_LOAD = 2'd1;
    localparam logic [1:0] SQ_ADD  = 2'd2;

    typedef logic signed [POS_W-1:0] pos_t;

    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] ident;
        pos_t            pos_x;
        pos_t            pos_y;
        pos_t            pos_z;
    } slot_t;

    typedef struct packed {
        logic  we;
        logic  wr_ident;
        slot_t data;
    } slot_wr_t;

endpackage

// File: rtl/core/thst_sq_unit.sv
// ----------------------------------------------------------------------------
// thst_sq_unit
// Shared difference-square accumulator: squares a - b and either loads or
// adds the result into a 32-bit accumulator, or holds it, one term per cycle.
// ----------------------------------------------------------------------------
module thst_sq_unit
    import thst_pkg::*;
(
    input  logic             clk,
    input  logic [1:0]       op,
    input  pos_t             a,
    input  pos_t             b,
    output logic [ACC_W-1:0] acc
);

    logic signed [POS_W:0]   diff;
    logic signed [ACC_W-1:0] prod;
    logic [ACC_W-1:0]        acc_reg;
    logic [ACC_W-1:0]        acc_next;

    assign diff = {a[POS_W-1], a} - {b[POS_W-1], b};
    assign prod = ACC_W'(diff) * ACC_W'(diff);

    always_comb
    begin
        case (op)
            SQ_LOAD: acc_next = unsigned'(prod);
            SQ_ADD:  acc_next = acc_reg + unsigned'(prod);
            default: acc_next = acc_reg;
        endcase
    end

    // accumulator is always loaded before it is read
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// File: rtl/core/thst_slot_store.sv
// ----------------------------------------------------------------------------
// thst_slot_store
// Slot records (flag, identifier, position), cleared at reset, with one
// read and one write through a shared slot index.
// ----------------------------------------------------------------------------
module thst_slot_store
    import thst_pkg::*;
#(
    parameter int NUM_SLOTS = 4,
    parameter int SW        = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [SW-1:0] idx,
    input  slot_wr_t      wr,
    output slot_t         rd
);

    slot_t slots_reg [NUM_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slots_reg[i] <= '0;
            end
        end
        else if (wr.we)
        begin
            slots_reg[idx].valid <= wr.data.valid;
            slots_reg[idx].pos_x <= wr.data.pos_x;
            slots_reg[idx].pos_y <= wr.data.pos_y;
            slots_reg[idx].pos_z <= wr.data.pos_z;
            if (wr.wr_ident)
            begin
                slots_reg[idx].ident <= wr.data.ident;
            end
        end
    end

    assign rd = slots_reg[idx];

endmodule

// File: rtl/core/tracked_hand_slot_table.sv
// ----------------------------------------------------------------------------
// tracked_hand_slot_table
// Table of tracked object slots driven by gesture, create, update and
// destroy requests, with one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests arrive on s_tvalid/s_tready with the command in s_tuser
//   and identifier and position in s_tdata. Each request yields exactly one
//   result on m_tvalid/m_tready. min_spacing and slots_in_use are written
//   over the APB port at byte addresses 0 and 4; the user must write them
//   only while the block idles, as the block itself does not enforce it.
//   One request at a time; s_tready is high only while the sequencer idles.
//   Create, update and destroy walk the slots one per cycle. A gesture with
//   nothing tracked is granted at once; otherwise the shared squaring unit
//   first forms the squared minimum distance, then takes three axis terms
//   and a compare per tracked slot and skips each free slot.
//   Reset clears every slot, the tracked count and the output valid flag and
//   restores min_spacing to 100 and slots_in_use to 4.
//   A stalled receiver holds the result in the output register; the next
//   request is still accepted and worked on, and waits to be shown until the
//   output register is free.
// ----------------------------------------------------------------------------
module tracked_hand_slot_table
    import thst_pkg::*;
#(
    parameter int NUM_SLOTS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // hand_id[31:0], pos_x[46:32], pos_y[61:47], pos_z[76:62]
    input  logic [1:0]  s_tuser,   // command[1:0]
    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // start_tracking[0], hit[1], slot_index[3:2],
                                   // tracked_count[6:4]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int AW = $clog2(NUM_SLOTS + 1);
    localparam int LW = (AW > COUNT_W) ? AW : COUNT_W;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_MD2     = 3'd1;
    localparam logic [2:0] ST_MDLATCH = 3'd2;
    localparam logic [2:0] ST_SCAN    = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [MIN_DIST_W-1:0] min_spacing_reg;
    logic [USE_W-1:0]      slots_in_use_reg;
    logic                  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_spacing_reg  <= MIN_SPACING_RESET;
            slots_in_use_reg <= SLOTS_IN_USE_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_MIN_SPACING)
            begin
                min_spacing_reg <= pwdata[MIN_DIST_W-1:0];
            end
            else
            begin
                slots_in_use_reg <= pwdata[USE_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_SLOTS_IN_USE) ? {{(32-USE_W){1'b0}}, slots_in_use_reg}
                                                   : {{(32-MIN_DIST_W){1'b0}}, min_spacing_reg};

    // Search length: slots_in_use clipped to the number of slots
    logic [LW-1:0] uses_w;
    logic [LW-1:0] num_w;
    logic [LW-1:0] search_len;

    assign uses_w     = LW'(slots_in_use_reg);
    assign num_w      = LW'(NUM_SLOTS);
    assign search_len = (uses_w > num_w) ? num_w : uses_w;

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    logic [2:0]    state_reg,  state_next;
    logic [LW-1:0] cnt_reg,    cnt_next;
    logic [1:0]    phase_reg,  phase_next;
    logic [AW-1:0] count_reg,  count_next;

    // request held for the whole walk
    logic [1:0]       cmd_reg,   cmd_next;
    logic [ID_W-1:0]  id_reg,    id_next;
    pos_t             px_reg,    px_next;
    pos_t             py_reg,    py_next;
    pos_t             pz_reg,    pz_next;
    logic [MD2_W-1:0] md2_reg,   md2_next;
    logic             start_reg, start_next;
    logic             hit_reg,   hit_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic                  out_start_reg, out_start_next;
    logic                  out_hit_reg,   out_hit_next;
    logic [SLOT_IDX_W-1:0] out_slot_reg,  out_slot_next;
    logic [COUNT_W-1:0]    out_count_reg, out_count_next;

    // shared unit and slot store
    logic [1:0]       sq_op;
    pos_t             sq_a;
    pos_t             sq_b;
    logic [ACC_W-1:0] sq_acc;
    slot_t            rd;
    slot_wr_t         wr;
    logic             scan_end;
    logic             out_free;
    logic [LW-1:0]    count_w;

    assign scan_end = (cnt_reg >= search_len);
    assign out_free = !out_valid_reg || m_tready;
    assign count_w  = LW'(count_reg);
    assign s_tready = (state_reg == ST_IDLE);

    thst_sq_unit u_sq
    (
        .clk (clk),
        .op  (sq_op),
        .a   (sq_a),
        .b   (sq_b),
        .acc (sq_acc)
    );

    thst_slot_store #(
        .NUM_SLOTS (NUM_SLOTS),
        .SW        (SW)
    ) u_store
    (
        .clk   (clk),
        .rst_n (rst_n),
        .idx   (cnt_reg[SW-1:0]),
        .wr    (wr),
        .rd    (rd)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        cmd_next   = cmd_reg;
        id_next    = id_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        pz_next    = pz_reg;
        md2_next   = md2_reg;
        start_next = start_reg;
        hit_next   = hit_reg;
        sq_op      = SQ_HOLD;
        sq_a       = px_reg;
        sq_b       = rd.pos_x;
        wr         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    // take the request and open the walk at slot 0
                    cmd_next   = s_tuser;
                    id_next    = s_tdata[31:0];
                    px_next    = s_tdata[46:32];
                    py_next    = s_tdata[61:47];
                    pz_next    = s_tdata[76:62];
                    cnt_next   = '0;
                    phase_next = '0;
                    hit_next   = 1'b0;
                    start_next = (s_tuser == CMD_GESTURE);
                    if (s_tuser == CMD_GESTURE)
                    begin
                        // nothing tracked: grant at once
                        state_next = (count_reg == '0) ? ST_DONE : ST_MD2;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_MD2:
            begin
                // square the minimum distance through the shared unit
                sq_op      = SQ_LOAD;
                sq_a       = {1'b0, min_spacing_reg};
                sq_b       = '0;
                state_next = ST_MDLATCH;
            end

            ST_MDLATCH:
            begin
                md2_next   = sq_acc[MD2_W-1:0];
                state_next = ST_SCAN;
            end

            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DONE;
                end
                else if (cmd_reg == CMD_GESTURE)
                begin
                    if (!rd.valid)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        // x term, y term, z term, then compare
                        case (phase_reg)
                            2'd0:
                            begin
                                sq_op = SQ_LOAD;
                                sq_a  = px_reg;
                                sq_b  = rd.pos_x;
                            end
                            2'd1:
                            begin
                                sq_op = SQ_ADD;
                                sq_a  = py_reg;
                                sq_b  = rd.pos_y;
                            end
                            2'd2:
                            begin
                                sq_op = SQ_ADD;
                                sq_a  = pz_reg;
                                sq_b  = rd.pos_z;
                            end
                            default:
                            begin
                                if (sq_acc < {{(ACC_W-MD2_W){1'b0}}, md2_reg})
                                begin
                                    start_next = 1'b0;
                                end
                                cnt_next = cnt_reg + 1'b1;
                            end
                        endcase
                        phase_next = phase_reg + 1'b1;
                    end
                end
                else if (cmd_reg == CMD_CREATE)
                begin
                    if (!rd.valid)
                    begin
                        // claim the first free slot
                        wr.we         = 1'b1;
                        wr.wr_ident   = 1'b1;
                        wr.data.valid = 1'b1;
                        wr.data.ident = id_reg;
                        wr.data.pos_x = px_reg;
                        wr.data.pos_y = py_reg;
                        wr.data.pos_z = pz_reg;
                        count_next    = count_reg + 1'b1;
                        hit_next      = 1'b1;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                else if (rd.ident == id_reg)
                begin
                    // first identifier match ends the walk, tracked or not
                    state_next = ST_DONE;
                    if (cmd_reg == CMD_UPDATE)
                    begin
                        if (rd.valid)
                        begin
                            wr.we         = 1'b1;
                            wr.data.valid = 1'b1;
                            wr.data.pos_x = px_reg;
                            wr.data.pos_y = py_reg;
                            wr.data.pos_z = pz_reg;
                            hit_next      = 1'b1;
                        end
                    end
                    else
                    begin
                        // drop position and flag, keep the identifier
                        wr.we = 1'b1;
                        if (rd.valid)
                        begin
                            hit_next = 1'b1;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: hold until taken, reload from the finished walk
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_start_next = out_start_reg;
        out_hit_next   = out_hit_reg;
        out_slot_next  = out_slot_reg;
        out_count_next = out_count_reg;
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_valid_next = 1'b1;
            out_start_next = start_reg;
            out_hit_next   = hit_reg;
            out_slot_next  = hit_reg ? cnt_reg[SLOT_IDX_W-1:0] : '0;
            out_count_next = count_w[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            phase_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        id_reg        <= id_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        pz_reg        <= pz_next;
        md2_reg       <= md2_next;
        start_reg     <= start_next;
        hit_reg       <= hit_next;
        out_start_reg <= out_start_next;
        out_hit_reg   <= out_hit_next;
        out_slot_reg  <= out_slot_next;
        out_count_reg <= out_count_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_slot_reg, out_hit_reg, out_start_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= AW'(NUM_SLOTS))
        else $error("tracked count exceeds slot count");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while the previous one is at work");

    a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wr.we |-> (state_reg == ST_SCAN) && !scan_end)
        else $error("slot written outside the walk");

    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SCAN) |=> $stable(count_reg))
        else $error("tracked count changed outside the walk");

endmodule

// File: tb/tracked_hand_slot_table_tb.sv
// ----------------------------------------------------------------------------
// tracked_hand_slot_table_tb
// Self-checking bench for the tracked hand slot table. A queue of gesture,
// create, update and destroy requests feeds a stream driver. A slot table
// model inside the bench predicts one result per accepted request, and a
// monitor compares each result with the oldest prediction. The run walks
// through several settings of min_spacing and slots_in_use, extremes
// included, written over APB only while the block is drained.
// ----------------------------------------------------------------------------
module tracked_hand_slot_table_tb;
    import thst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS    = 4;
    // Drain time covers the longest gesture walk.
    localparam int DRAIN_CYCLES = 4 * NUM_SLOTS + 8;
    // Cycles with no handshake of any kind before the run is abandoned.
    localparam int STALL_LIMIT  = 1000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 103;
    localparam int MAX_REPORTS  = 40;

    localparam logic [ID_W-1:0] ID_A = 32'h0000_00A5;
    localparam logic [ID_W-1:0] ID_B = 32'h5A5A_0001;
    localparam logic [ID_W-1:0] ID_C = 32'h8000_0000;
    localparam logic [ID_W-1:0] ID_D = 32'h1234_5679;
    localparam logic [ID_W-1:0] ID_UNKNOWN = 32'h1234_5678;

    typedef struct packed {
        logic [1:0]      command;
        logic [ID_W-1:0] hand_id;
        pos_t            pos_x;
        pos_t            pos_y;
        pos_t            pos_z;
    } hand_req_t;

    typedef struct packed {
        logic                  start_tracking;
        logic                  hit;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [COUNT_W-1:0]    tracked_count;
    } table_result_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;   // hand_id[31:0], pos_x[46:32], pos_y[61:47], pos_z[76:62]
    logic [1:0]  s_tuser  = '0;   // command[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // start_tracking[0], hit[1], slot_index[3:2],
                                  // tracked_count[6:4]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Slot table model: its own copy of the state and the registers
    logic                  tab_valid [NUM_SLOTS];
    logic [ID_W-1:0]       tab_ident [NUM_SLOTS];
    pos_t                  tab_x     [NUM_SLOTS];
    pos_t                  tab_y     [NUM_SLOTS];
    pos_t                  tab_z     [NUM_SLOTS];
    logic [COUNT_W-1:0]    tab_count;
    logic [MIN_DIST_W-1:0] tab_min_dist;
    logic [USE_W-1:0]      tab_use;

    hand_req_t     pending_reqs[$];   // requests not yet offered
    table_result_t results_due[$];    // predictions awaiting their result
    hand_req_t     recent_reqs[$];    // recent positions, used to aim requests
    hand_req_t     cur_req;

    logic [ID_W-1:0] id_pool [6];

    int idle_odds   = 0;   // chance out of 8 of starting an idle burst
    int send_gap    = 0;
    int recv_stall  = 0;
    int quiet_count = 0;
    int fail_count  = 0;

    tracked_hand_slot_table #(
        .NUM_SLOTS(NUM_SLOTS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Slot table model. Apply one request to the model state and return the
    // result it should produce.
    // ------------------------------------------------------------------------
    function automatic table_result_t predict_table(hand_req_t rq);
        table_result_t r;
        int            span;
        int            i;
        bit            done;
        longint        md2;
        longint        dx;
        longint        dy;
        longint        dz;
        r    = '0;
        done = 1'b0;
        // Search range clamps to the slot count; zero searches nothing
        span = (int'(tab_use) > NUM_SLOTS) ? NUM_SLOTS : int'(tab_use);
        case (rq.command)
            CMD_GESTURE:
            begin
                r.start_tracking = 1'b1;
                if (tab_count != 0)
                begin
                    md2 = longint'(tab_min_dist) * longint'(tab_min_dist);
                    for (i = 0; i < span; i++)
                    begin
                        dx = longint'(rq.pos_x) - longint'(tab_x[i]);
                        dy = longint'(rq.pos_y) - longint'(tab_y[i]);
                        dz = longint'(rq.pos_z) - longint'(tab_z[i]);
                        // Only tracked slots can block a new track
                        if (tab_valid[i] && (dx * dx + dy * dy + dz * dz < md2))
                            r.start_tracking = 1'b0;
                    end
                end
            end
            CMD_CREATE:
            begin
                for (i = 0; i < span; i++)
                begin
                    if (!done && !tab_valid[i])
                    begin
                        tab_valid[i]  = 1'b1;
                        tab_ident[i]  = rq.hand_id;
                        tab_x[i]      = rq.pos_x;
                        tab_y[i]      = rq.pos_y;
                        tab_z[i]      = rq.pos_z;
                        tab_count     = tab_count + 1'b1;
                        r.hit         = 1'b1;
                        r.slot_index  = 2'(i);
                        done          = 1'b1;
                    end
                end
            end
            default:
            begin
                // Update and destroy stop at the first matching identifier,
                // tracked or not
                for (i = 0; i < span; i++)
                begin
                    if (!done && tab_ident[i] == rq.hand_id)
                    begin
                        done = 1'b1;
                        if (rq.command == CMD_UPDATE)
                        begin
                            if (tab_valid[i])
                            begin
                                tab_x[i]     = rq.pos_x;
                                tab_y[i]     = rq.pos_y;
                                tab_z[i]     = rq.pos_z;
                                r.hit        = 1'b1;
                                r.slot_index = 2'(i);
                            end
                        end
                        else
                        begin
                            // Destroy keeps the identifier in the slot
                            tab_x[i] = '0;
                            tab_y[i] = '0;
                            tab_z[i] = '0;
                            if (tab_valid[i])
                            begin
                                tab_valid[i] = 1'b0;
                                if (tab_count != 0)
                                    tab_count = tab_count - 1'b1;
                                r.hit        = 1'b1;
                                r.slot_index = 2'(i);
                            end
                        end
                    end
                end
            end
        endcase
        r.tracked_count = tab_count;
        return r;
    endfunction

    // Offset a coordinate by up to +/- spread, saturated to the axis range
    function automatic pos_t near_pos(pos_t base, int spread);
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 16383)
            v = 16383;
        if (v < -16384)
            v = -16384;
        return pos_t'(v);
    endfunction

    // Build one random request. Identifiers come mostly from a small pool so
    // that updates and destroys find their slots; requests are mostly aimed
    // around recently created or moved positions to exercise the distance test.
    function automatic hand_req_t make_req();
        hand_req_t rq;
        int        pick;
        int        spread;
        int        k;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            rq.command = CMD_CREATE;
        else if (pick < 55)
            rq.command = CMD_UPDATE;
        else if (pick < 75)
            rq.command = CMD_DESTROY;
        else
            rq.command = CMD_GESTURE;
        if ($urandom_range(0, 99) < 85)
            rq.hand_id = id_pool[$urandom_range(0, 5)];
        else
            rq.hand_id = $urandom;
        spread = int'(tab_min_dist) + int'(tab_min_dist) / 2 + 2;
        pick   = $urandom_range(0, 99);
        if (recent_reqs.size() != 0 && pick < 65)
        begin
            k        = $urandom_range(0, recent_reqs.size() - 1);
            rq.pos_x = near_pos(recent_reqs[k].pos_x, spread);
            rq.pos_y = near_pos(recent_reqs[k].pos_y, spread);
            rq.pos_z = near_pos(recent_reqs[k].pos_z, spread);
        end
        else if (pick < 85)
        begin
            rq.pos_x = near_pos('0, 3000);
            rq.pos_y = near_pos('0, 3000);
            rq.pos_z = near_pos('0, 3000);
        end
        else
        begin
            rq.pos_x = pos_t'($urandom);
            rq.pos_y = pos_t'($urandom);
            rq.pos_z = pos_t'($urandom);
        end
        if (rq.command == CMD_CREATE || rq.command == CMD_UPDATE)
        begin
            recent_reqs.insert(recent_reqs.size(), rq);
            if (recent_reqs.size() > 8)
                void'(recent_reqs.pop_front());
        end
        return rq;
    endfunction

    function automatic void queue_req(logic [1:0] cmd, logic [ID_W-1:0] id,
                                      int x, int y, int z);
        hand_req_t rq;
        rq.command = cmd;
        rq.hand_id = id;
        rq.pos_x   = pos_t'(x);
        rq.pos_y   = pos_t'(y);
        rq.pos_z   = pos_t'(z);
        pending_reqs.insert(pending_reqs.size(), rq);
    endfunction

    // APB write: setup cycle, access cycle, register taken at the edge after.
    // Upper data bits are filled with noise; only the register width counts.
    task automatic write_reg(input logic idx, input logic [31:0] value);
        logic [31:0] keep;
        keep = (idx == REG_MIN_SPACING) ? 32'h0000_3FFF : 32'h0000_0007;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= (value & keep) | ($urandom & ~keep);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MIN_SPACING)
            tab_min_dist = value[MIN_DIST_W-1:0];
        else
            tab_use = value[USE_W-1:0];
        @(negedge clk);
    endtask

    // Hold until every request is accepted and answered, then let the block
    // settle for its worst-case latency.
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_tvalid || results_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic void report_field(string name, int want, int got);
        if (want != got)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d actual %0d",
                         $time, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stream driver: hold a request until accepted, predict it on acceptance,
    // and insert random idle bursts between requests.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                results_due.insert(results_due.size(), predict_table(cur_req));
                if (idle_odds != 0 && $urandom_range(0, 7) < idle_odds)
                    send_gap = $urandom_range(1, 12);
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    cur_req  = pending_reqs.pop_front();
                    s_tdata  <= {3'b000, cur_req.pos_z, cur_req.pos_y,
                                 cur_req.pos_x, cur_req.hand_id};
                    s_tuser  <= cur_req.command;
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: compare each accepted result with the oldest prediction
    // and stall the output side in random bursts.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (results_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result with no request outstanding, expected none actual %0h",
                                 $time, m_tdata);
                end
                else
                begin
                    want = results_due.pop_front();
                    report_field("start_tracking", want.start_tracking, m_tdata[0]);
                    report_field("hit", want.hit, m_tdata[1]);
                    report_field("slot_index", want.slot_index, m_tdata[3:2]);
                    report_field("tracked_count", want.tracked_count, m_tdata[6:4]);
                end
            end
            if (recv_stall != 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (idle_odds != 0 && $urandom_range(0, 7) < idle_odds)
                    recv_stall = $urandom_range(1, 12);
            end
        end
    end

    // Watchdog: abandon the run after too long with no handshake at all
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_count <= 0;
        else if (quiet_count >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_count <= quiet_count + 1;
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed requests, then random phases over a range of
    // settings. The last phase runs with no idling on either side.
    // ------------------------------------------------------------------------
    initial
    begin : sequence_run
        int phase_min  [PHASES];
        int phase_use  [PHASES];
        int phase_odds [PHASES];
        int p;
        int k;
        int md;

        phase_min  = '{16383, 0, 1, -1, 100, -1, 5000, 300};
        phase_use  = '{7, 2, 1, 3, 4, 0, 5, 4};
        phase_odds = '{3, 2, 5, 1, 0, 3, 2, 0};
        id_pool    = '{32'h0000_0000, 32'hFFFF_FFFF, ID_A, ID_B, ID_C, ID_D};

        for (k = 0; k < NUM_SLOTS; k++)
        begin
            tab_valid[k] = 1'b0;
            tab_ident[k] = '0;
            tab_x[k]     = '0;
            tab_y[k]     = '0;
            tab_z[k]     = '0;
        end
        tab_count    = '0;
        tab_min_dist = MIN_SPACING_RESET;
        tab_use      = SLOTS_IN_USE_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at reset settings, idling on
        idle_odds = 3;
        queue_req(CMD_GESTURE, $urandom, 16383, -16384, 0);      // nothing tracked
        queue_req(CMD_DESTROY, 32'h0, 0, 0, 0);                  // matches untracked slot
        queue_req(CMD_UPDATE, 32'h0, 7, 7, 7);                   // matches untracked slot
        queue_req(CMD_CREATE, 32'hFFFF_FFFF, 16383, 16383, 16383);
        queue_req(CMD_CREATE, 32'h0, -16384, -16384, -16384);
        queue_req(CMD_CREATE, ID_A, 0, 0, 0);
        queue_req(CMD_CREATE, ID_B, 300, 0, 0);
        queue_req(CMD_CREATE, ID_C, 1, 2, 3);                    // table full
        queue_req(CMD_GESTURE, 32'h0, 10, 20, -30);              // too close
        queue_req(CMD_GESTURE, 32'h0, 16383, 16383, 16283);      // exactly at the limit
        queue_req(CMD_GESTURE, 32'h0, 16383, 16383, 16284);      // just inside
        queue_req(CMD_UPDATE, 32'hFFFF_FFFF, -16384, 16383, 0);
        queue_req(CMD_UPDATE, ID_UNKNOWN, 5, 5, 5);              // no such identifier
        queue_req(CMD_DESTROY, ID_A, 9, 9, 9);
        queue_req(CMD_DESTROY, ID_A, 9, 9, 9);                   // identifier left behind
        queue_req(CMD_UPDATE, ID_A, 4, 4, 4);
        queue_req(CMD_GESTURE, 32'h0, 5, 5, 5);                  // freed slot ignored
        queue_req(CMD_CREATE, ID_C, 0, -1, 1);                   // reuses the freed slot
        wait_drained();

        // Zero minimum distance and an oversized search range
        write_reg(REG_MIN_SPACING, 32'd0);
        write_reg(REG_SLOTS_IN_USE, 32'd7);
        queue_req(CMD_GESTURE, 32'h0, 0, -1, 1);
        queue_req(CMD_DESTROY, 32'hFFFF_FFFF, 0, 0, 0);
        wait_drained();

        // Empty search range, widest spacing
        write_reg(REG_MIN_SPACING, 32'd16383);
        write_reg(REG_SLOTS_IN_USE, 32'd0);
        queue_req(CMD_CREATE, ID_D, 100, 100, 100);
        queue_req(CMD_GESTURE, 32'h0, 0, 0, 0);
        queue_req(CMD_DESTROY, 32'h0, 0, 0, 0);
        wait_drained();

        // One slot searched, the rest stay counted
        write_reg(REG_SLOTS_IN_USE, 32'd1);
        queue_req(CMD_GESTURE, 32'h0, 0, 0, 0);
        queue_req(CMD_CREATE, ID_D, -200, 300, -400);
        wait_drained();

        // Random phases
        for (p = 0; p < PHASES; p++)
        begin
            md = (phase_min[p] < 0) ? int'($urandom_range(1, 16383)) : phase_min[p];
            write_reg(REG_MIN_SPACING, md);
            write_reg(REG_SLOTS_IN_USE, phase_use[p]);
            idle_odds = phase_odds[p];
            for (k = 0; k < PHASE_ITEMS; k++)
                pending_reqs.insert(pending_reqs.size(), make_req());
            wait_drained();
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: tracked_hand_slot_table.f
rtl/core/thst_pkg.sv
rtl/core/thst_sq_unit.sv
rtl/core/thst_slot_store.sv
rtl/core/tracked_hand_slot_table.sv
tb/tracked_hand_slot_table_tb.sv
